### design/assert_macros.svh
// Assertion macros used by gradient_orientation_lut.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

### design/gol_pkg.sv
// ----------------------------------------------------------------------------
// gol_pkg
// Types, constants and the piecewise arctangent table for the orientation unit.
// ----------------------------------------------------------------------------
package gol_pkg;

    localparam int unsigned QuotW = 11;
    localparam int unsigned RemW  = 17;

    localparam logic [7:0] AngleBias = 8'd90;
    localparam logic [7:0] AngleMax  = 8'd180;
    localparam logic [7:0] AngleMin  = 8'd0;

    localparam logic [QuotW-1:0] BrkA = 11'd44;
    localparam logic [QuotW-1:0] BrkB = 11'd110;
    localparam logic [QuotW-1:0] BrkC = 11'd175;
    localparam logic [QuotW-1:0] BrkD = 11'd238;
    localparam logic [QuotW-1:0] BrkE = 11'd362;
    localparam logic [4:0] TopIndexMax = 5'd16;

    typedef logic [6:0] t_angle;

    localparam t_angle SegFine [0:44] = '{
        7'd0, 7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd8, 7'd9,
        7'd10, 7'd11, 7'd12, 7'd13, 7'd14, 7'd14, 7'd15, 7'd16, 7'd17, 7'd18,
        7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd22, 7'd23, 7'd24, 7'd25, 7'd25,
        7'd26, 7'd27, 7'd27, 7'd28, 7'd29, 7'd30, 7'd30, 7'd31, 7'd32, 7'd32,
        7'd33, 7'd33, 7'd34};
    localparam t_angle SegHalf [0:33] = '{
        7'd35, 7'd36, 7'd37, 7'd38, 7'd39, 7'd40, 7'd41, 7'd42, 7'd43, 7'd44,
        7'd45, 7'd46, 7'd47, 7'd47, 7'd48, 7'd49, 7'd50, 7'd50, 7'd51, 7'd52,
        7'd53, 7'd53, 7'd54, 7'd54, 7'd55, 7'd56, 7'd56, 7'd57, 7'd57, 7'd58,
        7'd58, 7'd59, 7'd59, 7'd59};
    localparam t_angle SegQuarter [0:16] = '{
        7'd60, 7'd60, 7'd61, 7'd62, 7'd63, 7'd63, 7'd64, 7'd65, 7'd65, 7'd66,
        7'd67, 7'd67, 7'd68, 7'd68, 7'd69, 7'd69, 7'd69};
    localparam t_angle SegEighth [0:7] = '{
        7'd70, 7'd71, 7'd71, 7'd72, 7'd73, 7'd73, 7'd74, 7'd74};
    localparam t_angle SegSixteenth [0:8] = '{
        7'd75, 7'd75, 7'd76, 7'd76, 7'd77, 7'd78, 7'd78, 7'd79, 7'd79};
    localparam t_angle SegSteep [0:16] = '{
        7'd80, 7'd81, 7'd82, 7'd83, 7'd84, 7'd84, 7'd85, 7'd85, 7'd85, 7'd86,
        7'd86, 7'd86, 7'd86, 7'd86, 7'd87, 7'd87, 7'd87};

    typedef struct packed {
        logic [RemW-1:0]  rem;
        logic [QuotW-1:0] low;
        logic [QuotW-1:0] quot;
        logic [15:0]      abs_x;
        logic             sign_diff;
        logic             x_zero;
        logic             y_pos;
        logic             y_neg;
        logic             ovf;
        logic [16:0]      strength;
    } t_stage;

    function automatic t_angle lookup_angle(input logic [QuotW-1:0] mag);
        logic [4:0] idx;
        t_angle     res;
        idx = 5'd0;
        if (mag > BrkE) begin
            idx = mag[10:6] - 5'd5;
            if (idx > TopIndexMax) begin
                idx = TopIndexMax;
            end
            res = SegSteep[idx];
        end else if (mag > BrkD) begin
            idx = mag[8:4] - 5'd14;
            res = SegSixteenth[idx[3:0]];
        end else if (mag > BrkC) begin
            idx = mag[7:3] - 5'd22;
            res = SegEighth[idx[2:0]];
        end else if (mag > BrkB) begin
            idx = 5'(mag[7:2] - 6'd27);
            res = SegQuarter[idx];
        end else if (mag > BrkA) begin
            res = SegHalf[6'(mag[6:1] - 6'd22)];
        end else begin
            res = SegFine[6'(mag[5:0])];
        end
        return res;
    endfunction

endpackage

### design/gol_if.sv
// ----------------------------------------------------------------------------
// gol_grad_if / gol_angle_if
// Valid/ready channels for the gradient pair and the orientation result.
// ----------------------------------------------------------------------------
interface gol_grad_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] grad_y;
    logic signed [15:0] grad_x;
    modport source (output valid, output grad_y, output grad_x, input ready);
    modport sink (input valid, input grad_y, input grad_x, output ready);
endinterface

interface gol_angle_if;
    logic        valid;
    logic        ready;
    logic [7:0]  orientation;
    logic [16:0] strength;
    modport source (output valid, output orientation, output strength, input ready);
    modport sink (input valid, input orientation, input strength, output ready);
endinterface

### design/gradient_orientation_lut.sv
// ----------------------------------------------------------------------------
// gradient_orientation_lut
// Gradient orientation (0..180 degrees) and L1 strength, one item per clock while o_angle is not stalled.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// i_grad    in   grad_y s16, grad_x s16
// o_angle   out  orientation u8, strength u17
//
// One item is taken per cycle while o_angle is not stalled; the result passes
// through thirteen register stages: input stage, eleven restoring divider
// stages, one quotient bit each, and the table stage.
// Reset is synchronous and active low and clears all valid bits.
// A stall on o_angle freezes the whole pipeline and holds every item in place.
`include "assert_macros.svh"
module gradient_orientation_lut (
    input  logic   i_clk,
    input  logic   i_rst_n,
    gol_grad_if.sink    i_grad,
    gol_angle_if.source o_angle
);
    import gol_pkg::*;

    localparam int unsigned NStage = QuotW + 1;

    t_stage      r_st [0:NStage-1];
    t_stage      n_st [0:NStage-1];
    logic        r_v  [0:NStage-1];
    logic        r_out_v;
    logic [7:0]  r_orient;
    logic [16:0] r_strength;
    logic        w_en;
    logic [15:0] w_ay;
    logic [15:0] w_ax;
    logic [QuotW-1:0] w_mag;
    t_angle      w_ang;
    logic        w_neg;
    logic [7:0]  n_orient;

    assign w_en = !r_out_v || o_angle.ready;
    assign i_grad.ready = w_en;

    always_comb begin
        w_ay = i_grad.grad_y[15] ? 16'(-i_grad.grad_y) : 16'(i_grad.grad_y);
        w_ax = i_grad.grad_x[15] ? 16'(-i_grad.grad_x) : 16'(i_grad.grad_x);
        n_st[0].rem       = {6'd0, w_ay[15:5]};
        n_st[0].low       = {w_ay[4:0], 6'd0};
        n_st[0].quot      = '0;
        n_st[0].abs_x     = w_ax;
        n_st[0].sign_diff = i_grad.grad_y[15] ^ i_grad.grad_x[15];
        n_st[0].x_zero    = (i_grad.grad_x == 16'sd0);
        n_st[0].y_pos     = !i_grad.grad_y[15] && (i_grad.grad_y != 16'sd0);
        n_st[0].y_neg     = i_grad.grad_y[15];
        n_st[0].ovf       = ({5'd0, w_ay[15:5]} >= w_ax);
        n_st[0].strength  = {1'b0, w_ay} + {1'b0, w_ax};
    end

    for (genvar k = 1; k < NStage; k++) begin : g_div
        logic [RemW-1:0] w_sh;
        logic            w_ge;
        always_comb begin
            w_sh = {r_st[k-1].rem[RemW-2:0], r_st[k-1].low[QuotW-1]};
            w_ge = (w_sh >= {1'b0, r_st[k-1].abs_x});
            n_st[k] = r_st[k-1];
            n_st[k].rem  = w_ge ? (w_sh - {1'b0, r_st[k-1].abs_x}) : w_sh;
            n_st[k].low  = {r_st[k-1].low[QuotW-2:0], 1'b0};
            n_st[k].quot = {r_st[k-1].quot[QuotW-2:0], w_ge};
        end
    end

    for (genvar k = 0; k < NStage; k++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en) begin
                r_v[k] <= (k == 0) ? i_grad.valid : r_v[(k == 0) ? 0 : k-1];
            end
            if (w_en) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_comb begin
        w_mag = r_st[NStage-1].ovf ? {QuotW{1'b1}} : r_st[NStage-1].quot;
        w_ang = lookup_angle(w_mag);
        w_neg = r_st[NStage-1].sign_diff && (w_mag != '0);
        if (r_st[NStage-1].x_zero) begin
            if (r_st[NStage-1].y_pos) begin
                n_orient = AngleMax;
            end else if (r_st[NStage-1].y_neg) begin
                n_orient = AngleMin;
            end else begin
                n_orient = AngleBias;
            end
        end else if (w_neg) begin
            n_orient = AngleBias - {1'b0, w_ang};
        end else begin
            n_orient = AngleBias + {1'b0, w_ang};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= r_v[NStage-1];
        end
        if (w_en) begin
            r_orient   <= n_orient;
            r_strength <= r_st[NStage-1].strength;
        end
    end

    assign o_angle.valid       = r_out_v;
    assign o_angle.orientation = r_orient;
    assign o_angle.strength    = r_strength;

    `ASSERT_IMPLY(a_ready_free, i_clk, i_rst_n, !r_out_v, i_grad.ready)
    `ASSERT_IMPLY(a_orient_range, i_clk, i_rst_n, r_out_v, r_orient <= AngleMax)
    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, r_out_v && !o_angle.ready, r_out_v && $stable(r_orient) && $stable(r_strength))
    `ASSERT_NEXT(a_last_stage_moves, i_clk, i_rst_n, r_v[NStage-1] && w_en, r_out_v)
endmodule

### tb/gradient_orientation_lut_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_orientation_lut_tb
// Self-checking testbench for the gradient orientation and strength unit.
// Gradient pairs go in over a valid/ready channel with random gaps. Each
// accepted item is predicted by a behavioral arctangent lookup. Results are
// compared in order, while the result side applies random backpressure.
// ----------------------------------------------------------------------------
module gradient_orientation_lut_tb;
    import gol_pkg::*;

    typedef struct {
        logic signed [15:0] gy;
        logic signed [15:0] gx;
    } t_grad;

    typedef struct {
        logic [7:0]  orientation;
        logic [16:0] strength;
    } t_result;

    localparam int BreakPoints[5] = '{44, 110, 175, 238, 362};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    gol_grad_if  grad ();
    gol_angle_if angle ();

    gradient_orientation_lut dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_grad  (grad.sink),
        .o_angle (angle.source)
    );

    t_grad   pending_grads[$];
    t_result expected_angles[$];
    int      cycle_count = 0;
    int      mismatch_count = 0;
    int      checked_count = 0;
    int      sent_count = 0;
    int      zero_x_count = 0;
    int      steep_count = 0;
    int      send_gap = 0;
    int      stall_count = 0;
    logic    grad_fire = 1'b0;
    logic    angle_fire = 1'b0;

    function automatic logic [6:0] arctan_segment(input int mag);
        int idx;
        if (mag > 362) begin
            idx = mag / 64 - 5;
            if (idx > 16) begin
                idx = 16;
            end
            return SegSteep[idx];
        end else if (mag > 238) begin
            return SegSixteenth[mag / 16 - 14];
        end else if (mag > 175) begin
            return SegEighth[mag / 8 - 22];
        end else if (mag > 110) begin
            return SegQuarter[mag / 4 - 27];
        end else if (mag > 44) begin
            return SegHalf[mag / 2 - 22];
        end
        return SegFine[mag];
    endfunction

    function automatic t_result predict_angle(input t_grad g);
        t_result r;
        int      gy;
        int      gx;
        int      slope;
        int      raw;
        gy = g.gy;
        gx = g.gx;
        if (gx == 0) begin
            raw = (gy > 0) ? 90 : ((gy < 0) ? -90 : 0);
        end else begin
            slope = (64 * gy) / gx;
            raw = (slope < 0) ? -int'(arctan_segment(-slope)) : int'(arctan_segment(slope));
        end
        r.orientation = 8'(raw + 90);
        r.strength = 17'((gy < 0 ? -gy : gy) + (gx < 0 ? -gx : gx));
        return r;
    endfunction

    function automatic int draw_wait();
        // One block in three, counted on cycle_count, runs with no idling at all.
        if ((cycle_count / 150) % 3 == 0) begin
            return 0;
        end
        return $urandom_range(0, 3);
    endfunction

    task automatic add_grad(input int gy, input int gx);
        t_grad g;
        g.gy = 16'(gy);
        g.gx = 16'(gx);
        pending_grads.push_back(g);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        grad_fire <= grad.valid && grad.ready;
        angle_fire <= angle.valid && angle.ready;
        if (i_rst_n && grad.valid && grad.ready) begin
            t_grad g;
            g.gy = grad.grad_y;
            g.gx = grad.grad_x;
            expected_angles.push_back(predict_angle(g));
            sent_count <= sent_count + 1;
            if (g.gx == 0) begin
                zero_x_count <= zero_x_count + 1;
            end else if ((64 * int'(g.gy)) / int'(g.gx) > 362
                         || (64 * int'(g.gy)) / int'(g.gx) < -362) begin
                steep_count <= steep_count + 1;
            end
        end
        if (i_rst_n && angle.valid && angle.ready) begin
            t_result exp_r;
            checked_count <= checked_count + 1;
            if (expected_angles.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10) begin
                    $display("ERROR: unexpected item orientation=%0d strength=%0d",
                             angle.orientation, angle.strength);
                end
            end else begin
                exp_r = expected_angles.pop_front();
                if (angle.orientation !== exp_r.orientation
                    || angle.strength !== exp_r.strength) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10) begin
                        $display("ERROR: orientation %0d/%0d strength %0d/%0d (exp/act)",
                                 exp_r.orientation, angle.orientation,
                                 exp_r.strength, angle.strength);
                    end
                end
            end
        end
        if (cycle_count > 200000) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            grad.valid <= 1'b0;
            grad.grad_y <= '0;
            grad.grad_x <= '0;
        end else if (!grad.valid || grad_fire) begin
            if (send_gap > 0) begin
                grad.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_grads.size() > 0) begin
                t_grad g;
                g = pending_grads.pop_front();
                grad.grad_y <= g.gy;
                grad.grad_x <= g.gx;
                grad.valid <= 1'b1;
                send_gap <= draw_wait();
            end else begin
                grad.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : b_sink
        int wait_cycles;
        if (!i_rst_n) begin
            angle.ready <= 1'b0;
        end else if (angle_fire) begin
            wait_cycles = draw_wait();
            if (wait_cycles == 0) begin
                angle.ready <= 1'b1;
            end else begin
                stall_count <= wait_cycles - 1;
                angle.ready <= 1'b0;
            end
        end else if (stall_count > 0) begin
            stall_count <= stall_count - 1;
            angle.ready <= 1'b0;
        end else begin
            angle.ready <= 1'b1;
        end
    end

    initial begin
        int mode;
        int gx;
        grad.valid = 1'b0;
        grad.grad_y = '0;
        grad.grad_x = '0;
        angle.ready = 1'b0;

        add_grad(0, 0);
        add_grad(5, 0);
        add_grad(-5, 0);
        add_grad(-32768, 0);
        add_grad(32767, 0);
        add_grad(0, 7);
        add_grad(32767, 32767);
        add_grad(-32768, -32768);
        add_grad(-32768, 1);
        add_grad(32767, -1);
        add_grad(1, -32768);
        add_grad(-100, 64);
        add_grad(2000, 64);
        foreach (BreakPoints[i]) begin
            add_grad(BreakPoints[i], 64);
            add_grad(-BreakPoints[i] - 1, 64);
        end

        for (int n = 0; n < 1800; n++) begin
            mode = $urandom_range(0, 2);
            if (mode == 0) begin
                add_grad($urandom_range(0, 65535), $urandom_range(0, 65535));
            end else if (mode == 1) begin
                add_grad(int'($urandom_range(0, 128)) - 64, int'($urandom_range(0, 128)) - 64);
            end else begin
                gx = $urandom_range(1, 512);
                if ($urandom_range(0, 1)) begin
                    gx = -gx;
                end
                add_grad(16'((gx * (int'($urandom_range(0, 1200)) - 600)) / 64), gx);
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_grads.size() == 0 && !grad.valid && expected_angles.size() == 0);
        repeat (30) @(posedge i_clk);

        $display("Checked %0d of %0d items, %0d with zero horizontal gradient, %0d steep.",
                 checked_count, sent_count, zero_x_count, steep_count);
        if (mismatch_count == 0 && expected_angles.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/gol_pkg.sv
design/gol_if.sv
design/gradient_orientation_lut.sv
tb/gradient_orientation_lut_tb.sv
